@@ rtl/sdsb_pkg.sv @@
// Shared types and constants for the stereo dual shelf biquad core.
// No dependencies; imported by stereo_dual_shelf_biquad_core.
package sdsb_pkg;

  // Defaults for the top level parameters
  localparam int CHANNELS_DEF       = 2;
  localparam int SAMPLE_BITS_DEF    = 24;
  localparam int COEF_FRAC_BITS_DEF = 20;

  // Fixed formats of the ports and coefficient registers
  localparam int PORT_SAMPLE_BITS = 24;
  localparam int COEF_BITS        = 24;
  localparam int CFG_DATA_BITS    = 48;
  localparam int CFG_INDEX_BITS   = 3;
  localparam int NUM_TERMS        = 5;
  localparam int NUM_SECTIONS     = 2;

  // 1.0 in Q3.20, the reset value of b0 in both sections
  localparam logic [COEF_BITS-1:0] COEF_UNITY = 24'h100000;

  // Coefficient slots within a section
  localparam int TERM_B0 = 0;
  localparam int TERM_B1 = 1;
  localparam int TERM_B2 = 2;
  localparam int TERM_A1 = 3;
  localparam int TERM_A2 = 4;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_LOW_B0_B1  = 3'd0,
    REG_LOW_B2_A1  = 3'd1,
    REG_LOW_A2     = 3'd2,
    REG_HIGH_B0_B1 = 3'd3,
    REG_HIGH_B2_A1 = 3'd4,
    REG_HIGH_A2    = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MAC,
    ST_ROUND,
    ST_EMIT
  } state_t;

endpackage

@@ rtl/stereo_dual_shelf_biquad_core.sv @@
// Stereo low shelf + high shelf biquad cascade with bit-serial multiply-accumulate.
// Depends on sdsb_pkg (types, register indexes, format constants).

// Each accepted item runs two direct-form-I sections one after the other.
// A section loads the coefficient shift registers, then walks the
// coefficient bits (all five products accumulated in parallel, one
// coefficient bit per cycle), then rounds, saturates and updates the channel
// history. The serial coefficient walk takes most of an item's time. A new
// item is accepted only after the previous result has moved into the output
// register, which waits while that register is full and not taken. An item
// whose channel is at or beyond CHANNELS gives a zero result and leaves all
// history alone. The result sits in an output register, so a new item can be
// taken while the previous result still waits. Coefficients must be written by
// the user only while idle; the block itself does not enforce this.
module stereo_dual_shelf_biquad_core #(
  parameter int CHANNELS       = sdsb_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS    = sdsb_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = sdsb_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic signed [sdsb_pkg::PORT_SAMPLE_BITS-1:0] in_sample_in,
  input  logic                                        in_channel,
  output logic                                        out_valid,
  input  logic                                        out_ready,
  output logic signed [sdsb_pkg::PORT_SAMPLE_BITS-1:0] out_sample_out,
  input  logic                                        cfg_we,
  input  logic        [sdsb_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic        [sdsb_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);
  import sdsb_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int PB    = PORT_SAMPLE_BITS;
  localparam int CB    = COEF_BITS;
  localparam int CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNTW  = $clog2(CB);
  localparam int DW    = SB + 1;          // data term, room for negated sample
  localparam int PW    = SB + 4;          // sum of five gated data terms
  localparam int HW    = SB + 5;          // high part of the accumulator
  localparam int ACC_W = HW + CB;

  localparam logic signed [ACC_W-1:0] Y_MAX = {{(ACC_W-SB+1){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] Y_MIN = ~Y_MAX;
  localparam logic signed [ACC_W-1:0] RND   = ACC_W'(1) << (COEF_FRAC_BITS - 1);

  state_t state_r, state_nxt;

  logic signed [CB-1:0] coef_r [NUM_SECTIONS][NUM_TERMS];
  logic        [CB-1:0] csh_r  [NUM_TERMS];
  logic        [CB-1:0] csh_nxt[NUM_TERMS];

  logic signed [SB-1:0] hx1_r [CHANNELS][NUM_SECTIONS];
  logic signed [SB-1:0] hx2_r [CHANNELS][NUM_SECTIONS];
  logic signed [SB-1:0] hy1_r [CHANNELS][NUM_SECTIONS];
  logic signed [SB-1:0] hy2_r [CHANNELS][NUM_SECTIONS];

  logic signed [HW-1:0]   h_r, h_nxt;
  logic        [CB-1:0]   l_r, l_nxt;
  logic        [CNTW-1:0] cnt_r, cnt_nxt;
  logic        [CHW-1:0]  ch_r, ch_nxt;
  logic                   sec_r, sec_nxt;
  logic signed [SB-1:0]   x_r, x_nxt;
  logic signed [SB-1:0]   y_r, y_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic signed [PB-1:0]   out_sample_r, out_sample_nxt;

  logic signed [SB-1:0]    x_in;
  logic signed [PB-1:0]    y_out;
  logic                    ch_ok;
  logic                    hist_we;
  logic                    out_load;
  logic                    mac_last;
  logic signed [DW-1:0]    dterm [NUM_TERMS];
  logic signed [PW-1:0]    psum;
  logic signed [HW-1:0]    tsum;
  logic signed [ACC_W-1:0] acc_full, acc_rnd, acc_sh;
  logic signed [SB-1:0]    y_new;

  // Input sample is its low SAMPLE_BITS bits as signed; zero-extended if wider than the port
  generate
    if (SB <= PB) begin : g_in_narrow
      assign x_in = in_sample_in[SB-1:0];
    end else begin : g_in_wide
      assign x_in = {{(SB-PB){1'b0}}, in_sample_in};
    end
    if (SB >= PB) begin : g_out_narrow
      assign y_out = y_r[PB-1:0];
    end else begin : g_out_wide
      assign y_out = {{(PB-SB){y_r[SB-1]}}, y_r};
    end
  endgenerate

  assign ch_ok    = 32'(in_channel) < CHANNELS;
  assign mac_last = (cnt_r == CNTW'(CB - 1));

  // Data terms; feedback terms enter negated so every product is added
  always_comb begin
    dterm[TERM_B0] = DW'(x_r);
    dterm[TERM_B1] = DW'(hx1_r[ch_r][sec_r]);
    dterm[TERM_B2] = DW'(hx2_r[ch_r][sec_r]);
    dterm[TERM_A1] = -DW'(hy1_r[ch_r][sec_r]);
    dterm[TERM_A2] = -DW'(hy2_r[ch_r][sec_r]);
  end

  always_comb begin
    psum = '0;
    for (int k = 0; k < NUM_TERMS; k++) begin
      if (csh_r[k][0]) begin
        psum = psum + PW'(dterm[k]);
      end
    end
    // coefficient sign bit carries negative weight
    tsum = mac_last ? (h_r - HW'(psum)) : (h_r + HW'(psum));
  end

  // Round half up, drop the fraction bits, clamp to the sample range
  always_comb begin
    acc_full = $signed({h_r, l_r});
    acc_rnd  = acc_full + RND;
    acc_sh   = acc_rnd >>> COEF_FRAC_BITS;
    if (acc_sh > Y_MAX) begin
      y_new = Y_MAX[SB-1:0];
    end else if (acc_sh < Y_MIN) begin
      y_new = Y_MIN[SB-1:0];
    end else begin
      y_new = acc_sh[SB-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    h_nxt     = h_r;
    l_nxt     = l_r;
    cnt_nxt   = cnt_r;
    ch_nxt    = ch_r;
    sec_nxt   = sec_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    csh_nxt   = csh_r;
    in_ready  = 1'b0;
    hist_we   = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ch_nxt  = CHW'(in_channel);
          x_nxt   = x_in;
          sec_nxt = 1'b0;
          if (ch_ok) begin
            state_nxt = ST_LOAD;
          end else begin
            y_nxt     = '0;
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_LOAD: begin
        for (int k = 0; k < NUM_TERMS; k++) begin
          csh_nxt[k] = coef_r[sec_r][k];
        end
        h_nxt     = '0;
        l_nxt     = '0;
        cnt_nxt   = '0;
        state_nxt = ST_MAC;
      end
      ST_MAC: begin
        for (int k = 0; k < NUM_TERMS; k++) begin
          csh_nxt[k] = csh_r[k] >> 1;
        end
        h_nxt   = tsum >>> 1;
        l_nxt   = {tsum[0], l_r[CB-1:1]};
        cnt_nxt = cnt_r + CNTW'(1);
        if (mac_last) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        hist_we = 1'b1;
        y_nxt   = y_new;
        if (!sec_r) begin
          sec_nxt   = 1'b1;
          x_nxt     = y_new;
          state_nxt = ST_LOAD;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_sample_nxt = out_sample_r;
    if (out_load) begin
      out_valid_nxt  = 1'b1;
      out_sample_nxt = y_out;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    h_r          <= h_nxt;
    l_r          <= l_nxt;
    cnt_r        <= cnt_nxt;
    ch_r         <= ch_nxt;
    sec_r        <= sec_nxt;
    x_r          <= x_nxt;
    y_r          <= y_nxt;
    csh_r        <= csh_nxt;
    out_sample_r <= out_sample_nxt;
  end

  // Per channel, per section history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        for (int s = 0; s < NUM_SECTIONS; s++) begin
          hx1_r[c][s] <= '0;
          hx2_r[c][s] <= '0;
          hy1_r[c][s] <= '0;
          hy2_r[c][s] <= '0;
        end
      end
    end else if (hist_we) begin
      hx2_r[ch_r][sec_r] <= hx1_r[ch_r][sec_r];
      hx1_r[ch_r][sec_r] <= x_r;
      hy2_r[ch_r][sec_r] <= hy1_r[ch_r][sec_r];
      hy1_r[ch_r][sec_r] <= y_new;
    end
  end

  // Coefficient registers, section 0 is the low shelf
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_SECTIONS; s++) begin
        for (int k = 0; k < NUM_TERMS; k++) begin
          coef_r[s][k] <= (k == TERM_B0) ? COEF_UNITY : '0;
        end
      end
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LOW_B0_B1: begin
          coef_r[0][TERM_B0] <= cfg_wdata[2*CB-1:CB];
          coef_r[0][TERM_B1] <= cfg_wdata[CB-1:0];
        end
        REG_LOW_B2_A1: begin
          coef_r[0][TERM_B2] <= cfg_wdata[2*CB-1:CB];
          coef_r[0][TERM_A1] <= cfg_wdata[CB-1:0];
        end
        REG_LOW_A2: coef_r[0][TERM_A2] <= cfg_wdata[CB-1:0];
        REG_HIGH_B0_B1: begin
          coef_r[1][TERM_B0] <= cfg_wdata[2*CB-1:CB];
          coef_r[1][TERM_B1] <= cfg_wdata[CB-1:0];
        end
        REG_HIGH_B2_A1: begin
          coef_r[1][TERM_B2] <= cfg_wdata[2*CB-1:CB];
          coef_r[1][TERM_A1] <= cfg_wdata[CB-1:0];
        end
        REG_HIGH_A2: coef_r[1][TERM_A2] <= cfg_wdata[CB-1:0];
        default: ;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  // Only one item in flight
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("new item taken while one is in flight");

  // Rounding follows a full walk of the coefficient bits
  a_full_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) |-> ($past(state_r) == ST_MAC && $past(cnt_r) == CNTW'(CB - 1)))
    else $error("section rounded before all coefficient bits were used");

  // A result appears only from the emit step
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> ($past(state_r) == ST_EMIT))
    else $error("result raised outside the emit step");

endmodule
